// ===== src/epe_pkg.sv =====
// shared types, constants and helpers for the pwm parameter editor
`timescale 1ns / 1ps

package epe_pkg;

    localparam int VALUE_BITS = 10;
    localparam int LIMIT_BITS = 10;
    localparam int ROW_COUNT  = 4;
    localparam int ROW_BITS   = 2;
    localparam int DIGIT_BITS = 2;
    localparam int MASK_BITS  = 4;
    localparam int REQ_BITS   = 3;
    localparam int STEP_BITS  = 10;
    // signed width for value plus or minus the largest step
    localparam int SUM_BITS   = VALUE_BITS + 2;

    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = DIGIT_BITS'(3);

    localparam logic [VALUE_BITS-1:0] PERIOD_RESET = VALUE_BITS'(192);
    localparam logic [VALUE_BITS-1:0] DUTY_RESET   = VALUE_BITS'(96);
    localparam logic [VALUE_BITS-1:0] PHASE_RESET  = VALUE_BITS'(48);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(1000);

    localparam logic [ROW_BITS-1:0] ROW_DUTY_A = ROW_BITS'(0);
    localparam logic [ROW_BITS-1:0] ROW_DUTY_B = ROW_BITS'(1);
    localparam logic [ROW_BITS-1:0] ROW_PHASE  = ROW_BITS'(2);
    localparam logic [ROW_BITS-1:0] ROW_PERIOD = ROW_BITS'(3);

    localparam logic [MASK_BITS-1:0] MASK_NONE   = 4'h0;
    localparam logic [MASK_BITS-1:0] MASK_DUTY_A = 4'h1;
    localparam logic [MASK_BITS-1:0] MASK_DUTY_B = 4'h2;
    localparam logic [MASK_BITS-1:0] MASK_PHASE  = 4'h4;
    localparam logic [MASK_BITS-1:0] MASK_ALL    = 4'hF;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_KNOB      = 3'd0,
        REQ_ROW_NEXT  = 3'd1,
        REQ_ROW_PREV  = 3'd2,
        REQ_DIGIT_DN  = 3'd3,
        REQ_DIGIT_UP  = 3'd4
    } t_req;

    typedef struct packed {
        logic [VALUE_BITS-1:0]                period;
        logic [VALUE_BITS-1:0]                duty_a;
        logic [VALUE_BITS-1:0]                duty_b;
        logic [VALUE_BITS-1:0]                phase;
        logic [ROW_BITS-1:0]                  row;
        logic [ROW_COUNT-1:0][DIGIT_BITS-1:0] digit_exp;
    } t_state;

    function automatic logic [STEP_BITS-1:0] pow10_step(input logic [DIGIT_BITS-1:0] d);
        logic [STEP_BITS-1:0] s;
        case (d)
            2'd0:    s = STEP_BITS'(1);
            2'd1:    s = STEP_BITS'(10);
            2'd2:    s = STEP_BITS'(100);
            default: s = STEP_BITS'(1000);
        endcase
        return s;
    endfunction

endpackage

// ===== src/epe_step.sv =====
// next-state logic for one editor request
`timescale 1ns / 1ps

module epe_step (
    input  epe_pkg::t_state                       i_state,
    input  logic [epe_pkg::LIMIT_BITS-1:0]        i_limit,
    input  logic [epe_pkg::REQ_BITS-1:0]          i_req_type,
    input  logic                                  i_turn_up,
    output epe_pkg::t_state                       o_state,
    output logic [epe_pkg::MASK_BITS-1:0]         o_mask,
    output logic [epe_pkg::DIGIT_BITS-1:0]        o_digit
);
    import epe_pkg::*;

    logic [ROW_BITS-1:0]         n_row;
    logic [DIGIT_BITS-1:0]       cur_digit;
    logic [STEP_BITS-1:0]        step;
    logic signed [SUM_BITS-1:0]  delta;
    logic signed [SUM_BITS-1:0]  per_s;
    logic signed [SUM_BITS-1:0]  lim_s;
    logic signed [SUM_BITS-1:0]  sum_a;
    logic signed [SUM_BITS-1:0]  sum_b;
    logic signed [SUM_BITS-1:0]  sum_ph;
    logic signed [SUM_BITS-1:0]  wrap_ph;
    logic signed [SUM_BITS-1:0]  sum_per;
    logic [VALUE_BITS-1:0]       new_a;
    logic [VALUE_BITS-1:0]       new_b;
    logic [VALUE_BITS-1:0]       new_ph;
    logic [VALUE_BITS-1:0]       new_per;
    t_req                        req;

    assign req = t_req'(i_req_type);

    // row changes only on row buttons, so one read at the new row serves all
    always_comb begin
        case (req)
            REQ_ROW_NEXT: n_row = i_state.row + ROW_BITS'(1);
            REQ_ROW_PREV: n_row = i_state.row - ROW_BITS'(1);
            default:      n_row = i_state.row;
        endcase
    end

    assign cur_digit = i_state.digit_exp[n_row];
    assign step      = pow10_step(cur_digit);
    assign delta     = i_turn_up ? $signed({{(SUM_BITS-STEP_BITS){1'b0}}, step})
                                 : -$signed({{(SUM_BITS-STEP_BITS){1'b0}}, step});
    assign per_s     = $signed({2'b00, i_state.period});
    assign lim_s     = $signed({{(SUM_BITS-LIMIT_BITS){1'b0}}, i_limit});

    assign sum_a   = $signed({2'b00, i_state.duty_a}) + delta;
    assign sum_b   = $signed({2'b00, i_state.duty_b}) + delta;
    assign sum_ph  = $signed({2'b00, i_state.phase}) + delta;
    assign sum_per = per_s + delta;

    always_comb begin
        if (sum_a > per_s)      new_a = i_state.period;
        else if (sum_a < 0)     new_a = '0;
        else                    new_a = sum_a[VALUE_BITS-1:0];

        if (sum_b > per_s)      new_b = i_state.period;
        else if (sum_b < 0)     new_b = '0;
        else                    new_b = sum_b[VALUE_BITS-1:0];

        // single wrap by the period, then clamp into 0..period-1
        if (sum_ph >= per_s)    wrap_ph = sum_ph - per_s;
        else if (sum_ph < 0)    wrap_ph = sum_ph + per_s;
        else                    wrap_ph = sum_ph;

        if (i_state.period == '0)        new_ph = '0;
        else if (wrap_ph > per_s - 1)    new_ph = i_state.period - VALUE_BITS'(1);
        else if (wrap_ph < 0)            new_ph = '0;
        else                             new_ph = wrap_ph[VALUE_BITS-1:0];

        if (sum_per > lim_s)    new_per = VALUE_BITS'(i_limit);
        else if (sum_per < 0)   new_per = '0;
        else                    new_per = sum_per[VALUE_BITS-1:0];
    end

    always_comb begin
        o_state     = i_state;
        o_state.row = n_row;
        o_mask      = MASK_NONE;
        o_digit     = cur_digit;
        case (req)
            REQ_KNOB: begin
                case (i_state.row)
                    ROW_DUTY_A: begin
                        o_state.duty_a = new_a;
                        o_mask         = MASK_DUTY_A;
                    end
                    ROW_DUTY_B: begin
                        o_state.duty_b = new_b;
                        o_mask         = MASK_DUTY_B;
                    end
                    ROW_PHASE: begin
                        o_state.phase = new_ph;
                        o_mask        = MASK_PHASE;
                    end
                    default: begin
                        // new period pulls the others back into range
                        o_state.period = new_per;
                        if (i_state.duty_a > new_per) o_state.duty_a = new_per;
                        if (i_state.duty_b > new_per) o_state.duty_b = new_per;
                        if (i_state.phase >= new_per) o_state.phase = '0;
                        o_mask = MASK_ALL;
                    end
                endcase
            end
            REQ_DIGIT_DN: begin
                if (cur_digit != '0) begin
                    o_digit = cur_digit - DIGIT_BITS'(1);
                end
                o_state.digit_exp[i_state.row] = o_digit;
            end
            REQ_DIGIT_UP: begin
                if (cur_digit != DIGIT_MAX) begin
                    o_digit = cur_digit + DIGIT_BITS'(1);
                end
                o_state.digit_exp[i_state.row] = o_digit;
            end
            default: begin
                o_mask = MASK_NONE;
            end
        endcase
    end

endmodule

// ===== src/encoder_pwm_param_editor.sv =====
// top level: request register, settings state and result register
`timescale 1ns / 1ps

// Editor for the period, two duties and phase of a two-output PWM, driven by
// knob steps and row/column buttons. One request is taken every clock cycle
// while results are taken as they appear. A result left waiting on the output
// lets one more request into the input register and then holds the input. A
// request is held in the input register, the settings update in combinational
// logic, and the result is registered in r_state and the output register that
// drives o_out_valid. The settings loop closes through r_state alone, so
// back-to-back requests each see the previous update. period_limit is to be
// written by the user through i_cfg_wr_en / i_cfg_wr_data only while no
// request is in flight; the block itself does not enforce this.

module encoder_pwm_param_editor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [epe_pkg::LIMIT_BITS-1:0]    i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [epe_pkg::REQ_BITS-1:0]      i_req_type,
    input  logic                              i_turn_up,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [epe_pkg::VALUE_BITS-1:0]    o_period_value,
    output logic [epe_pkg::VALUE_BITS-1:0]    o_duty_a_value,
    output logic [epe_pkg::VALUE_BITS-1:0]    o_duty_b_value,
    output logic [epe_pkg::VALUE_BITS-1:0]    o_phase_value,
    output logic [epe_pkg::MASK_BITS-1:0]     o_changed_mask,
    output logic [epe_pkg::ROW_BITS-1:0]      o_row_now,
    output logic [epe_pkg::DIGIT_BITS-1:0]    o_digit_now
);
    import epe_pkg::*;

    logic [LIMIT_BITS-1:0]  r_limit;
    logic                   r_in_valid;
    logic [REQ_BITS-1:0]    r_in_req;
    logic                   r_in_up;
    t_state                 r_state;
    t_state                 n_state;
    logic [MASK_BITS-1:0]   n_mask;
    logic [DIGIT_BITS-1:0]  n_digit;
    logic                   r_out_valid;
    logic [MASK_BITS-1:0]   r_out_mask;
    logic [DIGIT_BITS-1:0]  r_out_digit;
    logic                   fire;

    // request moves to the result register when that register is free
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    epe_step u_step (
        .i_state    (r_state),
        .i_limit    (r_limit),
        .i_req_type (r_in_req),
        .i_turn_up  (r_in_up),
        .o_state    (n_state),
        .o_mask     (n_mask),
        .o_digit    (n_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req <= i_req_type;
            r_in_up  <= i_turn_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.period    <= PERIOD_RESET;
            r_state.duty_a    <= DUTY_RESET;
            r_state.duty_b    <= DUTY_RESET;
            r_state.phase     <= PHASE_RESET;
            r_state.row       <= ROW_DUTY_A;
            r_state.digit_exp <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_mask  <= n_mask;
            r_out_digit <= n_digit;
        end
    end

    // state register doubles as the value part of the result
    assign o_out_valid    = r_out_valid;
    assign o_period_value = r_state.period;
    assign o_duty_a_value = r_state.duty_a;
    assign o_duty_b_value = r_state.duty_b;
    assign o_phase_value  = r_state.phase;
    assign o_row_now      = r_state.row;
    assign o_changed_mask = r_out_mask;
    assign o_digit_now    = r_out_digit;

endmodule
